>>> hw/rtl/oaht_pkg.sv
package oaht_pkg;

  localparam int unsigned OpW    = 2;
  localparam int unsigned KindW  = 2;
  localparam int unsigned WordW  = 64;
  localparam int unsigned StatW  = 2;
  localparam int unsigned LimitW = 6;
  localparam logic [LimitW-1:0] LoadLimitRst = 6'd48;

  typedef enum logic [OpW-1:0] {
    OP_GET = 2'd0,
    OP_SET = 2'd1,
    OP_DEL = 2'd2,
    OP_NOP = 2'd3
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_RSVD     = 2'd3
  } status_e;

  localparam logic [1:0] MarkEmpty = 2'd0;
  localparam logic [1:0] MarkLive  = 2'd1;
  localparam logic [1:0] MarkTomb  = 2'd2;

  localparam logic [KindW-1:0] KindBool = 2'd0;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [KindW-1:0] key_kind;
    logic [WordW-1:0] key_word;
    logic [WordW-1:0] new_value;
  } req_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic             was_new_key;
    logic [WordW-1:0] read_value;
  } rsp_t;

  // req_t with the folded hash, built by the front end
  typedef struct packed {
    req_t        req;
    logic [31:0] hash;
  } cmd_t;

endpackage

>>> hw/rtl/oaht_if.sv
interface oaht_req_if;
  logic              valid;
  logic              ready;
  oaht_pkg::req_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface oaht_rsp_if;
  logic              valid;
  logic              ready;
  oaht_pkg::rsp_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface oaht_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [oaht_pkg::LimitW-1:0]   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/oaht_front.sv
module oaht_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  oaht_req_if.sink              req,
  output logic                  cmd_valid_o,
  input  logic                  cmd_ready_i,
  output oaht_pkg::cmd_t        cmd_o
);
  import oaht_pkg::*;

  // two-entry queue toward the probe engine
  cmd_t       q_mem [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cmd;
  logic       push, pop;

  always_comb begin
    cmd.req = req.payload;
    if (req.payload.key_kind == KindBool) begin
      cmd.req.key_word = {{(WordW-1){1'b0}}, req.payload.key_word[0]};
      cmd.hash = {31'd0, req.payload.key_word[0]};
    end else begin
      cmd.hash = req.payload.key_word[31:0] ^ req.payload.key_word[63:32];
    end
  end

  assign req.ready   = (cnt_q != 2'd2);
  assign push        = req.valid && req.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem[rd_ptr_q];
  assign wr_ptr_d    = wr_ptr_q ^ push;
  assign rd_ptr_d    = rd_ptr_q ^ pop;
  assign cnt_d       = cnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> (cnt_q == 2'd2)) else $error("full queue lost entry");

endmodule

>>> hw/rtl/oaht_back.sv
module oaht_back #(
  parameter int unsigned Slots = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  oaht_pkg::cmd_t              cmd_i,
  input  logic [oaht_pkg::LimitW-1:0] load_limit_i,
  oaht_rsp_if.source                  rsp
);
  import oaht_pkg::*;

  localparam int unsigned IdxW = $clog2(Slots);
  localparam int unsigned CntW = IdxW + 1;
  localparam int unsigned UsedW = 7;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRead  = 3'd1;
  localparam logic [2:0] StCheck = 3'd2;
  localparam logic [2:0] StWrite = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;
  localparam logic [2:0] StClear = 3'd5;

  // marks live in a memory too; a clearing pass empties them after reset
  logic [1:0]       mark_mem  [Slots];
  logic [KindW-1:0] kind_mem  [Slots];
  logic [WordW-1:0] key_mem   [Slots];
  logic [WordW-1:0] value_mem [Slots];

  logic [2:0]       state_q, state_d;
  cmd_t             cmd_q;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  n_q, n_d;
  logic             tomb_vld_q, tomb_vld_d;
  logic [IdxW-1:0]  tomb_q, tomb_d;
  logic [UsedW-1:0] used_q, used_d;
  rsp_t             rsp_q, rsp_d;
  logic             rsp_vld_q, rsp_vld_d;

  logic [1:0]       rd_mark_q;
  logic [KindW-1:0] rd_kind_q;
  logic [WordW-1:0] rd_key_q, rd_val_q;

  logic             wr_en;
  logic [IdxW-1:0]  wr_idx;
  logic [1:0]       wr_mark;
  logic             wr_data;  // also write key, kind and value
  logic             wr_val_only;

  logic [IdxW-1:0]  idx_inc;
  logic             hit, last;

  assign idx_inc = idx_q + 1'b1;
  assign hit  = (rd_mark_q == MarkLive) && (rd_kind_q == cmd_q.req.key_kind)
             && (rd_key_q == cmd_q.req.key_word);
  assign last = (n_q == CntW'(Slots - 1));

  assign cmd_ready_o = (state_q == StIdle) && !rsp_vld_q;
  assign rsp.valid   = rsp_vld_q;
  assign rsp.payload = rsp_q;

  always_ff @(posedge clk_i) begin
    rd_mark_q <= mark_mem[idx_d];
    rd_kind_q <= kind_mem[idx_d];
    rd_key_q  <= key_mem[idx_d];
    rd_val_q  <= value_mem[idx_d];
    if (wr_en) mark_mem[wr_idx] <= wr_mark;
    if (wr_data) begin
      kind_mem[wr_idx] <= cmd_q.req.key_kind;
      key_mem[wr_idx]  <= cmd_q.req.key_word;
    end
    if (wr_data || wr_val_only) value_mem[wr_idx] <= cmd_q.req.new_value;
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    n_d         = n_q;
    tomb_vld_d  = tomb_vld_q;
    tomb_d      = tomb_q;
    used_d      = used_q;
    rsp_d       = rsp_q;
    rsp_vld_d   = rsp_vld_q;
    wr_en       = 1'b0;
    wr_idx      = idx_q;
    wr_mark     = MarkLive;
    wr_data     = 1'b0;
    wr_val_only = 1'b0;
    if (rsp_vld_q && rsp.ready) rsp_vld_d = 1'b0;
    unique case (state_q)
      StClear: begin
        wr_en   = 1'b1;
        wr_mark = MarkEmpty;
        idx_d   = idx_inc;
        if (idx_q == IdxW'(Slots - 1)) begin
          state_d = StIdle;
          idx_d   = '0;
        end
      end
      StIdle: begin
        if (cmd_valid_i && cmd_ready_o) begin
          idx_d      = cmd_i.hash[IdxW-1:0];
          n_d        = '0;
          tomb_vld_d = 1'b0;
          state_d    = (op_e'(cmd_i.req.opcode) == OP_NOP) ? StOut : StRead;
          rsp_d      = '{status: ST_OK, was_new_key: 1'b0, read_value: '0};
        end
      end
      StRead: state_d = StCheck;  // memory read latency
      StCheck: begin
        if (hit) begin
          state_d = StOut;
          case (op_e'(cmd_q.req.opcode))
            OP_GET: rsp_d.read_value = rd_val_q;
            OP_SET: wr_val_only = 1'b1;
            default: begin
              wr_en   = 1'b1;
              wr_mark = MarkTomb;
            end
          endcase
        end else if (rd_mark_q == MarkEmpty || last) begin
          state_d = StOut;
          if (op_e'(cmd_q.req.opcode) != OP_SET) begin
            rsp_d.status = ST_NOTFOUND;
          end else if (tomb_vld_q || (rd_mark_q == MarkTomb && !last ? 1'b0 :
                       (rd_mark_q == MarkTomb))) begin
            // reuse first tombstone
            wr_idx  = (tomb_vld_q) ? tomb_q : idx_q;
            wr_en   = 1'b1;
            wr_data = 1'b1;
            rsp_d.was_new_key = 1'b1;
          end else if (rd_mark_q == MarkEmpty &&
                       (used_q + 1'b1) <= {1'b0, load_limit_i}) begin
            wr_en   = 1'b1;
            wr_data = 1'b1;
            used_d  = used_q + 1'b1;
            rsp_d.was_new_key = 1'b1;
          end else begin
            rsp_d.status = ST_FULL;
          end
        end else begin
          if (rd_mark_q == MarkTomb && !tomb_vld_q) begin
            tomb_vld_d = 1'b1;
            tomb_d     = idx_q;
          end
          idx_d   = idx_inc;
          n_d     = n_q + 1'b1;
          state_d = StCheck;
        end
      end
      StWrite: state_d = StOut;
      StOut: begin
        if (!rsp_vld_q || rsp.ready) begin
          rsp_vld_d = 1'b1;
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && cmd_ready_o) cmd_q <= cmd_i;
    tomb_q <= tomb_d;
    rsp_q  <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClear;
      idx_q      <= '0;
      n_q        <= '0;
      tomb_vld_q <= 1'b0;
      used_q     <= '0;
      rsp_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      n_q        <= n_d;
      tomb_vld_q <= tomb_vld_d;
      used_q     <= used_d;
      rsp_vld_q  <= rsp_vld_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_vld_q && !rsp.ready) |=> (rsp_vld_q && $stable(rsp_q)))
    else $error("response changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= Slots) else $error("used count beyond table size");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCheck && !hit && !last && rd_mark_q != MarkEmpty) |=>
      (n_q == $past(n_q) + 1'b1)) else $error("probe count did not advance");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_vld_q && rsp_q.status != ST_OK) |-> !rsp_q.was_new_key)
    else $error("new key flagged on failure");

endmodule

>>> hw/rtl/open_address_hash_table_top.sv
// Key/value table of Slots entries with linear probing and tombstones. Requests
// queue in a two-entry buffer and are served one at a time: an operation passes
// through a read state, then a check state that probes the slots (one memory
// read a cycle, up to Slots), then an output state that hands over the result;
// a no-op skips the read and the probe. After reset a clearing pass over all
// Slots entries empties the table before the first request is served.
// load_limit may be written only while no request is in flight.
module open_address_hash_table_top #(
  parameter int unsigned Slots = 64
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  oaht_req_if.sink   req,
  oaht_rsp_if.source rsp,
  oaht_cfg_if.sink   cfg
);
  import oaht_pkg::*;

  logic              cmd_valid, cmd_ready;
  cmd_t              cmd;
  logic [LimitW-1:0] load_limit_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_limit_q <= LoadLimitRst;
    end else if (cfg.valid) begin
      load_limit_q <= cfg.payload;
    end
  end

  oaht_front u_front (
    .clk_i, .rst_ni, .req,
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  oaht_back #(.Slots(Slots)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .load_limit_i (load_limit_q),
    .rsp
  );

endmodule

>>> tb/tb_open_address_hash_table_top.sv
module tb_open_address_hash_table_top;
  timeunit 1ns;
  timeprecision 1ps;
  import oaht_pkg::*;

  localparam int unsigned Slots      = 64;
  localparam int unsigned RunLimit   = 1000000;
  localparam int unsigned DrainWait  = 100;
  localparam int unsigned PhaseItems = 210;
  localparam int unsigned PoolSize   = 16;

  localparam logic [KindW-1:0] KindInt  = 2'd1;
  localparam logic [KindW-1:0] KindDbl  = 2'd2;
  localparam logic [KindW-1:0] KindOdd  = 2'd3;
  localparam logic [WordW-1:0] AllOnes  = {WordW{1'b1}};

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  oaht_req_if req_if ();
  oaht_rsp_if rsp_if ();
  oaht_cfg_if cfg_if ();

  open_address_hash_table_top #(.Slots(Slots)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_if),
    .rsp    (rsp_if),
    .cfg    (cfg_if)
  );

  // shadow copy of the table
  logic [1:0]       shadow_mark [Slots];
  logic [KindW-1:0] shadow_kind [Slots];
  logic [WordW-1:0] shadow_key  [Slots];
  logic [WordW-1:0] shadow_val  [Slots];
  int unsigned      shadow_used;
  logic [LimitW-1:0] shadow_limit;

  rsp_t        pending_rsp [$];
  stim_row_t   directed [$];
  req_t        key_pool [PoolSize];
  int unsigned mismatches;
  bit          calm;
  bit          want_hold;
  longint unsigned cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > RunLimit) begin
        $display("tb_open_address_hash_table_top failed");
        $finish;
      end
    end
  end

  function automatic rsp_t table_access(req_t r);
    rsp_t             res;
    logic [KindW-1:0] kind;
    logic [WordW-1:0] word;
    logic [31:0]      hash;
    int               idx;
    int               hit;
    int               tomb;
    int               target;
    bit               stopped;
    res    = '0;
    kind   = r.key_kind;
    word   = (kind == KindBool) ? {63'd0, r.key_word[0]} : r.key_word;
    hash   = (kind == KindBool) ? {31'd0, word[0]} : (word[31:0] ^ word[63:32]);
    idx    = hash % Slots;
    hit    = -1;
    tomb   = -1;
    target = -1;
    stopped = 1'b0;
    if (op_e'(r.opcode) == OP_NOP) return res;
    for (int n = 0; n < Slots && !stopped; n++) begin
      if (shadow_mark[idx] == MarkEmpty) begin
        target  = (tomb >= 0) ? tomb : idx;
        stopped = 1'b1;
      end else if (shadow_mark[idx] == MarkTomb) begin
        if (tomb < 0) tomb = idx;
      end else if (shadow_kind[idx] == kind && shadow_key[idx] == word) begin
        hit     = idx;
        target  = idx;
        stopped = 1'b1;
      end
      idx = (idx + 1) % Slots;
    end
    if (!stopped) target = tomb;
    case (op_e'(r.opcode))
      OP_GET: begin
        if (hit >= 0) res.read_value = shadow_val[hit];
        else res.status = ST_NOTFOUND;
      end
      OP_SET: begin
        if (hit >= 0) begin
          shadow_val[hit] = r.new_value;
        end else if (target < 0) begin
          res.status = ST_FULL;
        end else if (shadow_mark[target] == MarkEmpty && shadow_used + 1 > shadow_limit) begin
          res.status = ST_FULL;
        end else begin
          if (shadow_mark[target] == MarkEmpty) shadow_used = (shadow_used + 1) & 7'h7f;
          shadow_mark[target] = MarkLive;
          shadow_kind[target] = kind;
          shadow_key[target]  = word;
          shadow_val[target]  = r.new_value;
          res.was_new_key     = 1'b1;
        end
      end
      OP_DEL: begin
        if (hit >= 0) shadow_mark[hit] = MarkTomb;
        else res.status = ST_NOTFOUND;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic req_t make_req(op_e op, logic [KindW-1:0] kind, logic [WordW-1:0] word,
                                    logic [WordW-1:0] value);
    req_t r;
    r.opcode    = op;
    r.key_kind  = kind;
    r.key_word  = word;
    r.new_value = value;
    return r;
  endfunction

  function automatic rsp_t make_rsp(status_e st, logic isnew, logic [WordW-1:0] rd);
    rsp_t s;
    s.status      = st;
    s.was_new_key = isnew;
    s.read_value  = rd;
    return s;
  endfunction

  function automatic void add_row(req_t r, bit typed, rsp_t want);
    stim_row_t row;
    row.req   = r;
    row.typed = typed;
    row.want  = want;
    directed.push_back(row);
  endfunction

  task automatic send_req(req_t r, bit typed, rsp_t want);
    rsp_t predicted;
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk_i); while (!req_if.ready);
    predicted = table_access(r);
    pending_rsp.push_back(typed ? want : predicted);
  endtask

  task automatic write_limit(logic [LimitW-1:0] lim);
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= lim;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    shadow_limit = lim;
  endtask

  function automatic logic [WordW-1:0] rand_word();
    logic [31:0] lo;
    lo = $urandom;
    case ($urandom_range(0, 4))
      0: return {32'd0, 26'd0, lo[5:0]};
      1: return {lo, lo ^ {26'd0, lo[5:0]}};
      2: return {$urandom, $urandom};
      3: return {lo[3:0], 28'd0, 28'd0, lo[7:4]};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t        r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 4) != 0) begin
      r = key_pool[$urandom_range(0, PoolSize - 1)];
    end else begin
      r.key_kind = KindW'($urandom_range(0, 3));
      r.key_word = {$urandom, $urandom};
    end
    r.new_value = {$urandom, $urandom};
    if (pick < 35)      r.opcode = OP_GET;
    else if (pick < 75) r.opcode = OP_SET;
    else if (pick < 95) r.opcode = OP_DEL;
    else                r.opcode = OP_NOP;
    return r;
  endfunction

  // response side: random stalls, one long hold-off on request
  initial begin
    forever begin
      if (want_hold) begin
        want_hold = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    rsp_t got;
    rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.payload;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response transfer: %p", got);
      end else begin
        want = pending_rsp.pop_front();
        if (got.status !== want.status || got.was_new_key !== want.was_new_key ||
            got.read_value !== want.read_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("response mismatch: expected st=%0d new=%0d rd=%h got st=%0d new=%0d rd=%h",
                     want.status, want.was_new_key, want.read_value,
                     got.status, got.was_new_key, got.read_value);
        end
      end
    end
  end

  initial begin
    logic [LimitW-1:0] phase_limit [5];
    rsp_t none;
    none         = '0;
    mismatches   = 0;
    calm         = 1'b0;
    want_hold    = 1'b0;
    shadow_used  = 0;
    shadow_limit = LoadLimitRst;
    for (int i = 0; i < Slots; i++) begin
      shadow_mark[i] = MarkEmpty;
      shadow_kind[i] = '0;
      shadow_key[i]  = '0;
      shadow_val[i]  = '0;
    end
    phase_limit = '{6'd8, 6'd63, 6'd1, 6'd30, 6'd63};
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.payload <= '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_row(make_req(OP_GET, KindBool, 64'd0, 64'd0), 1, make_rsp(ST_NOTFOUND, 0, 0));
    add_row(make_req(OP_SET, KindBool, AllOnes, AllOnes), 1, make_rsp(ST_OK, 1, 0));
    add_row(make_req(OP_GET, KindBool, 64'd1, 64'd0), 1, make_rsp(ST_OK, 0, AllOnes));
    add_row(make_req(OP_SET, KindInt, 64'd0, 64'd0), 1, make_rsp(ST_OK, 1, 0));
    add_row(make_req(OP_SET, KindDbl, 64'd0, 64'd5), 1, make_rsp(ST_OK, 1, 0));
    // negative zero is a different key
    add_row(make_req(OP_SET, KindDbl, 64'h8000_0000_0000_0000, 64'd6), 1, make_rsp(ST_OK, 1, 0));
    add_row(make_req(OP_GET, KindDbl, 64'd0, AllOnes), 1, make_rsp(ST_OK, 0, 64'd5));
    add_row(make_req(OP_SET, KindInt, 64'd0, 64'd7), 1, make_rsp(ST_OK, 0, 0));
    add_row(make_req(OP_GET, KindInt, 64'd0, 64'd0), 1, make_rsp(ST_OK, 0, 64'd7));
    add_row(make_req(OP_NOP, KindOdd, AllOnes, AllOnes), 1, none);
    add_row(make_req(OP_SET, KindOdd, 64'd0, 64'd9), 1, make_rsp(ST_OK, 1, 0));
    add_row(make_req(OP_GET, KindOdd, 64'd0, 64'd0), 1, make_rsp(ST_OK, 0, 64'd9));
    add_row(make_req(OP_DEL, KindInt, 64'd0, AllOnes), 1, make_rsp(ST_OK, 0, 0));
    add_row(make_req(OP_GET, KindInt, 64'd0, 64'd0), 1, make_rsp(ST_NOTFOUND, 0, 0));
    add_row(make_req(OP_DEL, KindInt, 64'd0, 64'd0), 1, make_rsp(ST_NOTFOUND, 0, 0));
    add_row(make_req(OP_SET, KindInt, 64'd64, 64'd11), 0, none);
    // tombstone on the path was reused by key 64 above; this key takes an empty slot
    add_row(make_req(OP_SET, KindInt, 64'd0, 64'd1), 1, make_rsp(ST_OK, 1, 0));
    add_row(make_req(OP_SET, KindInt, AllOnes, AllOnes), 0, none);
    add_row(make_req(OP_GET, KindInt, AllOnes, 64'd0), 0, none);
    add_row(make_req(OP_SET, KindDbl, 64'h7ff8_0000_0000_0001, 64'd3), 0, none);
    add_row(make_req(OP_GET, KindDbl, 64'h7ff8_0000_0000_0001, 64'd0), 0, none);
    add_row(make_req(OP_DEL, KindBool, 64'd0, 64'd0), 1, make_rsp(ST_NOTFOUND, 0, 0));
    foreach (directed[i]) send_req(directed[i].req, directed[i].typed, directed[i].want);

    // lowest limit: the table is already past it
    write_limit(6'd1);
    send_req(make_req(OP_SET, KindInt, 64'd12345, 64'd1), 1, make_rsp(ST_FULL, 0, 0));
    send_req(make_req(OP_SET, KindInt, 64'd0, 64'd2), 1, make_rsp(ST_OK, 0, 0));

    for (int p = 0; p < 5; p++) begin
      write_limit(phase_limit[p]);
      calm = (p == 4);
      for (int k = 0; k < PoolSize; k++) begin
        key_pool[k].key_kind = KindW'($urandom_range(0, 3));
        key_pool[k].key_word = rand_word();
      end
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == 1 && n == 20) want_hold = 1'b1;
        send_req(rand_req(), 0, none);
      end
    end
    req_if.valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("tb_open_address_hash_table_top passed");
    end else begin
      $display("tb_open_address_hash_table_top failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/oaht_pkg.sv
hw/rtl/oaht_if.sv
hw/rtl/oaht_front.sv
hw/rtl/oaht_back.sv
hw/rtl/open_address_hash_table_top.sv
tb/tb_open_address_hash_table_top.sv
